// ----- sv/iira_pkg.sv -----
// Package for the indexed insert/remove array store.
// Holds operation and status codes, the controller state type and the result struct.
// No dependencies.
package iira_pkg;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] word_out;
        logic [6:0]  placed_at;
        logic [6:0]  count_out;
    } t_result;

endpackage

// ----- sv/iira_mem.sv -----
// Entry store: simple dual-port synchronous RAM, one write and one read port.
// Read data registered. No dependencies.
module iira_mem #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    parameter int AW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/iira_ctrl.sv -----
// Sequencer for the array store: decodes an item, runs the read-modify-write
// shift through the entry RAM and hands one result out. Uses iira_pkg.
module iira_ctrl import iira_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_op,
    input  logic [6:0]           i_position_in,
    input  logic [31:0]          i_word_in,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [WORD_BITS-1:0] o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  logic [WORD_BITS-1:0] i_rdata
);

    localparam int LW = (CW > 7) ? CW : 7;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [WORD_BITS-1:0] r_word, n_word;
    t_status              r_status, n_status;
    logic [31:0]          r_rword, n_rword;
    logic [6:0]           r_placed, n_placed;

    logic [LW-1:0]        pos_ext, cnt_ext;
    logic [CW-1:0]        raddr_full, waddr_full;
    logic                 accept;
    logic                 full;

    assign pos_ext = LW'(i_position_in);
    assign cnt_ext = LW'(r_count);
    assign full    = (r_count >= CW'(DEPTH));
    assign accept  = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_status <= n_status;
        r_rword  <= n_rword;
        r_placed <= n_placed;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_word     = r_word;
        n_status   = r_status;
        n_rword    = r_rword;
        n_placed   = r_placed;
        o_we       = 1'b0;
        waddr_full = '0;
        o_wdata    = r_word;
        raddr_full = '0;
        o_in_ready = (r_state == S_IDLE);
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_rword  = '0;
                    n_placed = '0;
                    n_word   = WORD_BITS'(i_word_in);
                    n_pos    = CW'(pos_ext);
                    n_state  = S_DONE;
                    case (t_op'(i_op))
                        OP_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we       = 1'b1;
                                waddr_full = r_count;
                                o_wdata    = WORD_BITS'(i_word_in);
                                n_placed   = 7'(r_count);
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_ext == cnt_ext) begin
                                o_we       = 1'b1;
                                waddr_full = r_count;
                                o_wdata    = WORD_BITS'(i_word_in);
                                n_placed   = 7'(r_count);
                                n_count    = r_count + CW'(1);
                            end else begin
                                // open the gap from the top down
                                raddr_full = r_count - CW'(1);
                                n_idx      = r_count;
                                n_placed   = i_position_in;
                                n_state    = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (pos_ext == cnt_ext - LW'(1)) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                raddr_full = CW'(pos_ext) + CW'(1);
                                n_idx      = CW'(pos_ext);
                                n_state    = S_SHIFT_DN;
                            end
                        end
                        OP_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                raddr_full = CW'(pos_ext);
                                n_state    = S_READ_WAIT;
                            end
                        end
                        OP_WRITE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_we       = 1'b1;
                                waddr_full = CW'(pos_ext);
                                o_wdata    = WORD_BITS'(i_word_in);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                // rdata holds entry r_idx-1
                o_we       = 1'b1;
                waddr_full = r_idx;
                o_wdata    = i_rdata;
                if (r_idx == r_pos + CW'(1)) begin
                    n_state = S_PLACE;
                end else begin
                    raddr_full = r_idx - CW'(2);
                    n_idx      = r_idx - CW'(1);
                end
            end
            S_PLACE: begin
                o_we       = 1'b1;
                waddr_full = r_pos;
                o_wdata    = r_word;
                n_count    = r_count + CW'(1);
                n_state    = S_DONE;
            end
            S_SHIFT_DN: begin
                // rdata holds entry r_idx+1
                o_we       = 1'b1;
                waddr_full = r_idx;
                o_wdata    = i_rdata;
                if (r_idx == r_count - CW'(2)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    raddr_full = r_idx + CW'(2);
                    n_idx      = r_idx + CW'(1);
                end
            end
            S_READ_WAIT: begin
                n_rword = 32'(i_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_waddr = waddr_full[AW-1:0];
    assign o_raddr = raddr_full[AW-1:0];

    assign o_res.status    = r_status;
    assign o_res.word_out  = r_rword;
    assign o_res.placed_at = r_placed;
    assign o_res.count_out = 7'(r_count);

endmodule

// ----- sv/indexed_insert_remove_array.sv -----
// Ordered array store of up to DEPTH words with insert/remove by position.
// Each input item gives exactly one result item. Append, write, insert at
// the end, remove of the last entry and any rejected item go straight from
// the accepting edge to the done state; read passes through a wait state
// for the registered RAM data; insert at position p below the count and
// remove at p below count - 1 step through a shift state (insert then a
// place state), and the shift moves one entry per cycle through the single
// read and single write port of the entry RAM. The worst case is insert at
// position 0 of a store holding DEPTH-1 entries. One item is worked on at a
// time; the sequencer is ready again in the cycle after its result is handed
// on, and it takes the next item while a finished result still sits in the
// output register. No clearing pass after reset: only entries below the
// count are ever read.
// Depends on iira_pkg, iira_ctrl and iira_mem.
module indexed_insert_remove_array import iira_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [6:0]  i_position_in,
    input  logic [31:0] i_word_in,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_word_out,
    output logic [6:0]  o_placed_at,
    output logic [6:0]  o_count_out
);

    // RAM address width; count/index width able to hold DEPTH itself
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    logic    res_valid, res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    iira_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_position_in (i_position_in),
        .i_word_in     (i_word_in),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata)
    );

    iira_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register: decouples the sequencer from a stalled consumer
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_word_out  = r_out.word_out;
    assign o_placed_at = r_out.placed_at;
    assign o_count_out = r_out.count_out;

endmodule

// ----- sv/iira_chk.sv -----
// Port-level checker for indexed_insert_remove_array, with its bind.
// Uses iira_pkg status codes.
module iira_chk import iira_pkg::*; #(
    parameter int DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_word_out,
    input logic [6:0]  o_placed_at,
    input logic [6:0]  o_count_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_word_out) && $stable(o_placed_at) && $stable(o_count_out))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_word_out == '0) && (o_placed_at == '0))
        else $error("rejected item carries data");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_RANGE)
            || (o_status == ST_FULL))
        else $error("bad status code");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> (o_count_out == 7'(DEPTH)))
        else $error("full reported below capacity");

    a_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DEPTH < 128) |-> (o_count_out <= 7'(DEPTH))
            && ((o_placed_at == '0) || (o_placed_at < o_count_out)))
        else $error("count or placement out of range");

endmodule

bind indexed_insert_remove_array iira_chk #(.DEPTH(DEPTH)) u_iira_chk (.*);

// ----- test/indexed_insert_remove_array_tb.sv -----
// Self-checking testbench for the indexed insert/remove array store.
// Predicts each result item from a shadow store and count; valid/ready on both sides.
// Depends on iira_pkg and indexed_insert_remove_array.
`timescale 1ns / 1ps

module indexed_insert_remove_array_tb import iira_pkg::*;;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 1250;  // random items, spare op codes included
    localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  pos;
        logic [31:0] word;
    } t_request;

    // Random phases steer the fill level: grow towards full, drain towards
    // empty, or wander.
    typedef enum logic [1:0] {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } t_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_op          = '0;
    logic [6:0]  i_position_in = '0;
    logic [31:0] i_word_in     = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_word_out;
    logic [6:0]  o_placed_at;
    logic [6:0]  o_count_out;

    // Items waiting to be offered, and results owed by the block, oldest first.
    t_request    pending_q[$];
    t_result     results_due[$];

    // Shadow of the block's contents, updated as each item is accepted.
    logic [31:0] store_words[DEPTH];
    int unsigned store_count = 0;

    // Fill level as the generator sees it, used only to aim positions.
    int unsigned gen_count = 0;

    logic        in_taken     = 1'b0;  // input item accepted at the last rising edge
    int unsigned n_accepted   = 0;
    int unsigned n_results    = 0;
    int unsigned n_errors     = 0;
    int unsigned idle_cycles  = 0;

    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned stall_left   = 0;
    int unsigned recv_calm    = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 200;

    indexed_insert_remove_array #(
        .DEPTH     (DEPTH),
        .WORD_BITS (32)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_position_in (i_position_in),
        .i_word_in     (i_word_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_word_out    (o_word_out),
        .o_placed_at   (o_placed_at),
        .o_count_out   (o_count_out)
    );

    always #5 i_clk = ~i_clk;

    // Reset held low from time zero, released on a falling edge.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic flag_error(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    // Shadow store: applies one item and returns the result it owes.
    function automatic t_result store_apply(t_request req);
        t_result     res;
        int unsigned p;
        p            = req.pos;
        res.status   = ST_OK;
        res.word_out = '0;
        res.placed_at = '0;
        case (req.op)
            OP_APPEND, OP_INSERT: begin
                if (req.op == OP_APPEND) begin
                    p = store_count;
                end
                if (p > store_count) begin
                    res.status = ST_RANGE;      // range is checked before full
                end else if (store_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned i = store_count; i > p; i--) begin
                        store_words[i] = store_words[i - 1];
                    end
                    store_words[p] = req.word;
                    store_count++;
                    res.placed_at = 7'(p);
                end
            end
            OP_REMOVE: begin
                if (p >= store_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int unsigned i = p; i + 1 < store_count; i++) begin
                        store_words[i] = store_words[i + 1];
                    end
                    store_count--;
                end
            end
            OP_READ: begin
                if (p >= store_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.word_out = store_words[p];
                end
            end
            OP_WRITE: begin
                if (p >= store_count) begin
                    res.status = ST_RANGE;
                end else begin
                    store_words[p] = req.word;
                end
            end
            default: ;                          // spare codes: no effect
        endcase
        res.count_out = 7'(store_count);
        return res;
    endfunction

    // Queues an item and tracks the fill level it will leave behind.
    function automatic void enqueue_request(logic [2:0] op, logic [6:0] pos,
                                            logic [31:0] word);
        t_request r;
        r.op   = op;
        r.pos  = pos;
        r.word = word;
        pending_q.push_back(r);
        case (op)
            OP_APPEND: if (gen_count < DEPTH) gen_count++;
            OP_INSERT: if (pos <= gen_count && gen_count < DEPTH) gen_count++;
            OP_REMOVE: if (pos < gen_count) gen_count--;
            default: ;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(t_phase ph);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        case (ph)
            PH_GROW: begin
                if (roll < 40) return OP_APPEND;
                if (roll < 75) return OP_INSERT;
                if (roll < 80) return OP_REMOVE;
                if (roll < 90) return OP_READ;
                return OP_WRITE;
            end
            PH_SHRINK: begin
                if (roll < 55) return OP_REMOVE;
                if (roll < 63) return OP_APPEND;
                if (roll < 70) return OP_INSERT;
                if (roll < 85) return OP_READ;
                return OP_WRITE;
            end
            default: begin
                if (roll < 22) return OP_APPEND;
                if (roll < 41) return OP_INSERT;
                if (roll < 62) return OP_REMOVE;
                if (roll < 81) return OP_READ;
                return OP_WRITE;
            end
        endcase
    endfunction

    // Mostly valid positions, with edges, one-past-the-end and wild values mixed in.
    function automatic logic [6:0] pick_pos(logic [2:0] op, int unsigned cnt);
        int unsigned top;
        int unsigned roll;
        top  = (op == OP_INSERT) ? cnt : cnt - 1;
        roll = $urandom_range(0, 99);
        if (op == OP_APPEND || roll >= 95) begin
            return 7'($urandom_range(0, 127));
        end
        if (roll >= 88 || (op != OP_INSERT && cnt == 0)) begin
            return 7'((op == OP_INSERT) ? cnt + 1 : cnt);
        end
        if (roll >= 80) begin
            return ($urandom_range(0, 1) != 0) ? 7'(top) : 7'd0;
        end
        return 7'($urandom_range(0, top));
    endfunction

    // Idle length: mostly none or short, now and then long; a calm stretch
    // suppresses idling altogether for a while.
    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 249) == 0) begin
            calm = $urandom_range(40, 150);
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stimulus: a directed opening, then random phases; afterwards wait for
    // the block to drain and give the verdict.
    initial begin : stimulus
        int unsigned rand_items;
        int unsigned phase_len;
        t_phase      ph;
        logic [2:0]  op;

        // empty store: every positional op is out of range
        enqueue_request(OP_READ,   7'd0,   32'h0000_0000);
        enqueue_request(OP_REMOVE, 7'd0,   32'h0000_0000);
        enqueue_request(OP_WRITE,  7'd0,   32'hFFFF_FFFF);
        enqueue_request(OP_INSERT, 7'd1,   32'h1111_1111);  // past the end
        // build a few entries: front, tail, end-insert, middle-insert
        enqueue_request(OP_INSERT, 7'd0,   32'hFFFF_FFFF);
        enqueue_request(OP_APPEND, 7'd127, 32'h0000_0000);
        enqueue_request(OP_APPEND, 7'd0,   32'h5A5A_A5A5);
        enqueue_request(OP_INSERT, 7'd3,   32'h1234_5678);
        enqueue_request(OP_INSERT, 7'd1,   32'h8000_0001);
        enqueue_request(OP_READ,   7'd0,   32'h0000_0000);
        enqueue_request(OP_READ,   7'd4,   32'h0000_0000);  // last entry
        enqueue_request(OP_READ,   7'd5,   32'h0000_0000);  // one past
        enqueue_request(OP_WRITE,  7'd2,   32'h7FFF_FFFE);
        enqueue_request(OP_READ,   7'd2,   32'h0000_0000);
        // remove front, tail and middle
        enqueue_request(OP_REMOVE, 7'd0,   32'h0000_0000);
        enqueue_request(OP_REMOVE, 7'd3,   32'h0000_0000);
        enqueue_request(OP_REMOVE, 7'd1,   32'h0000_0000);
        // spare op codes leave everything alone
        enqueue_request(OP_SPARE_LO,          7'd127, 32'hFFFF_FFFF);
        enqueue_request(OP_SPARE_LO + 3'd1,   7'd0,   32'h0000_0000);
        enqueue_request(OP_SPARE_HI,          7'd64,  32'hDEAD_BEEF);
        // wild positions
        enqueue_request(OP_READ,   7'd127, 32'h0000_0000);
        enqueue_request(OP_INSERT, 7'd127, 32'hFFFF_FFFF);
        enqueue_request(OP_INSERT, 7'd64,  32'hFFFF_FFFF);
        enqueue_request(OP_WRITE,  7'd1,   32'hFFFF_FFFF);
        enqueue_request(OP_REMOVE, 7'd2,   32'h0000_0000);  // position == count

        // First phase grows the store towards full so the full cases get exercised.
        ph         = PH_GROW;
        rand_items = 0;
        while (rand_items < N_RANDOM) begin
            phase_len = (ph == PH_GROW) ? $urandom_range(100, 160)
                                        : $urandom_range(40, 120);
            repeat (phase_len) begin
                if (rand_items < N_RANDOM) begin
                    op = pick_op(ph);
                    enqueue_request(op, pick_pos(op, gen_count), $urandom());
                    rand_items++;
                end
            end
            ph = t_phase'($urandom_range(0, 2));
        end

        // Everything offered and taken, then every owed result back.
        while (pending_q.size() > 0 || i_in_valid || results_due.size() > 0) begin
            @(negedge i_clk);
        end
        // Room for any stray result: longest shift plus slack.
        repeat (DEPTH + 16) @(negedge i_clk);
        if (results_due.size() != 0) begin
            flag_error($sformatf("%0d result items never arrived", results_due.size()));
        end
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Sender: offers the next queued item on the falling edge, holding it
    // until taken, with random gaps between items.
    always @(negedge i_clk) begin
        t_request nxt;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (i_in_valid) begin
                send_gap = draw_gap(send_calm);     // item just went in
            end
            if (send_gap == 0 && pending_q.size() > 0) begin
                nxt            = pending_q.pop_front();
                i_in_valid    <= 1'b1;
                i_op          <= nxt.op;
                i_position_in <= nxt.pos;
                i_word_in     <= nxt.word;
            end else begin
                i_in_valid <= 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off every few hundred items
    // so the block backs up and refuses input while the sender keeps trying.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left == 0 && n_accepted >= next_hold_at) begin
                hold_left    = $urandom_range(150, 300);
                next_hold_at = next_hold_at + 450;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = draw_gap(recv_calm);
                end
            end
        end
    end

    // Monitor: predicts on each accepted input item and checks each accepted
    // result item against the oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_request req;
        t_result  want;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_taken) begin
            req.op   = i_op;
            req.pos  = i_position_in;
            req.word = i_word_in;
            results_due.push_back(store_apply(req));
            n_accepted++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                flag_error("result item arrived with nothing expected");
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status) begin
                    flag_error($sformatf("result %0d: status %0d, expected %0d",
                                         n_results, o_status, want.status));
                end
                if (o_word_out !== want.word_out) begin
                    flag_error($sformatf("result %0d: word_out %h, expected %h",
                                         n_results, o_word_out, want.word_out));
                end
                if (o_placed_at !== want.placed_at) begin
                    flag_error($sformatf("result %0d: placed_at %0d, expected %0d",
                                         n_results, o_placed_at, want.placed_at));
                end
                if (o_count_out !== want.count_out) begin
                    flag_error($sformatf("result %0d: count_out %0d, expected %0d",
                                         n_results, o_count_out, want.count_out));
                end
            end
            n_results++;
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_ready) && !(o_out_valid && i_out_ready)) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule
